### rtl/m4ci_pkg.sv
// Shared types, state codes and the cofactor micro-op table for the 4x4 inverse core.
package m4ci_pkg;

    localparam int ELEM_W = 16;
    localparam int MIN2_W = 33;
    localparam int COF_W  = 49;
    localparam int PROD_W = 65;
    localparam int DET_W  = 68;
    localparam int QSH    = 17;
    localparam int DSH_W  = DET_W + QSH;

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_COF_RD   = 4'd1;
    localparam logic [3:0] S_COF_EX   = 4'd2;
    localparam logic [3:0] S_COF_AC   = 4'd3;
    localparam logic [3:0] S_COF_WR   = 4'd4;
    localparam logic [3:0] S_DET_RD   = 4'd5;
    localparam logic [3:0] S_DET_EX   = 4'd6;
    localparam logic [3:0] S_DET_AC   = 4'd7;
    localparam logic [3:0] S_DET_FIN  = 4'd8;
    localparam logic [3:0] S_DIV_RD   = 4'd9;
    localparam logic [3:0] S_DIV_INIT = 4'd10;
    localparam logic [3:0] S_DIV_STEP = 4'd11;
    localparam logic [3:0] S_DIV_OUT  = 4'd12;

    localparam logic [2:0] K_LD    = 3'd0;
    localparam logic [2:0] K_M2SET = 3'd1;
    localparam logic [2:0] K_M2SUB = 3'd2;
    localparam logic [2:0] K_M3SET = 3'd3;
    localparam logic [2:0] K_M3SUB = 3'd4;
    localparam logic [2:0] K_M3ADD = 3'd5;

    localparam logic [3:0] LAST_OP = 4'd14;

    typedef struct packed {
        logic [1:0] rsel;
        logic [1:0] csel;
        logic [2:0] kind;
    } t_op;

    // 3x3 minor a(ek-fh) - b(dk-fg) + c(dh-eg), one element read per op
    function automatic t_op op_entry(input logic [3:0] idx);
        t_op o;
        unique case (idx)
            4'd0:    o = '{2'd1, 2'd1, K_LD};
            4'd1:    o = '{2'd2, 2'd2, K_M2SET};
            4'd2:    o = '{2'd1, 2'd2, K_LD};
            4'd3:    o = '{2'd2, 2'd1, K_M2SUB};
            4'd4:    o = '{2'd0, 2'd0, K_M3SET};
            4'd5:    o = '{2'd1, 2'd0, K_LD};
            4'd6:    o = '{2'd2, 2'd2, K_M2SET};
            4'd7:    o = '{2'd1, 2'd2, K_LD};
            4'd8:    o = '{2'd2, 2'd0, K_M2SUB};
            4'd9:    o = '{2'd0, 2'd1, K_M3SUB};
            4'd10:   o = '{2'd1, 2'd0, K_LD};
            4'd11:   o = '{2'd2, 2'd1, K_M2SET};
            4'd12:   o = '{2'd1, 2'd1, K_LD};
            4'd13:   o = '{2'd2, 2'd0, K_M2SUB};
            4'd14:   o = '{2'd0, 2'd2, K_M3ADD};
            default: o = '{2'd0, 2'd0, K_LD};
        endcase
        return o;
    endfunction

    function automatic logic [1:0] skip_idx(input logic [1:0] sel, input logic [1:0] excl);
        return (sel < excl) ? sel : sel + 2'd1;
    endfunction

endpackage

### rtl/m4ci_ram.sv
// Generic single-write, single-read RAM with registered read data.
module m4ci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mat4_cofactor_inverse_core.sv
// Top level of the 4x4 matrix inverse core: load, cofactors, determinant, division.
// Cofactors and determinant share one 49x16 multiplier; each quotient comes from an
// 18-step restoring divider, and a singular matrix emits its 16 words without division.
// A new matrix is accepted only after the last result word of the previous one is issued.
// Reset: synchronous active-low; clears sequencer and output valid, not the stores.
module mat4_cofactor_inverse_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_elem_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_inv_value,
    output logic [3:0]  o_inv_index,
    output logic        o_inv_last,
    output logic        o_singular,
    output logic        o_saturated
);

    localparam int ESH = 2 * FRAC_BITS;

    logic [3:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] r_ci, n_ci;
    logic [4:0] r_bit, n_bit;

    logic signed [m4ci_pkg::ELEM_W-1:0] r_opa;
    logic signed [m4ci_pkg::MIN2_W-1:0] r_acc2;
    logic signed [m4ci_pkg::COF_W-1:0]  r_acc3;
    logic signed [m4ci_pkg::PROD_W-1:0] r_prod;
    logic signed [m4ci_pkg::DET_W-1:0]  r_det;
    logic [m4ci_pkg::DET_W-1:0]         r_dmag;
    logic                               r_sing;
    logic                               r_dneg;
    logic                               r_neg;
    logic [m4ci_pkg::DSH_W-1:0]         r_rem;
    logic [m4ci_pkg::DSH_W-1:0]         r_dsh;
    logic [m4ci_pkg::QSH:0]             r_q;

    logic        r_out_valid;
    logic [15:0] r_inv_value;
    logic [3:0]  r_inv_index;
    logic        r_inv_last;
    logic        r_singular;
    logic        r_saturated;

    m4ci_pkg::t_op cur_op;
    logic [1:0]    op_row;
    logic [1:0]    op_col;

    logic                                mat_we;
    logic [3:0]                          mat_raddr;
    logic [m4ci_pkg::ELEM_W-1:0]         mat_rdata;
    logic                                cof_we;
    logic [3:0]                          cof_raddr;
    logic signed [m4ci_pkg::COF_W-1:0]   cof_wdata;
    logic [m4ci_pkg::COF_W-1:0]          cof_rdata;

    logic signed [m4ci_pkg::COF_W-1:0]   mul_x;
    logic signed [m4ci_pkg::ELEM_W-1:0]  mul_y;
    logic signed [m4ci_pkg::PROD_W-1:0]  mul_p;

    logic signed [m4ci_pkg::COF_W-1:0]   cv;
    logic [m4ci_pkg::COF_W-1:0]          cmag;
    logic                                ge;
    logic                                q_sat;
    logic [15:0]                         q_val;
    logic [15:0]                         id_val;
    logic                                out_free;

    assign cur_op = m4ci_pkg::op_entry(r_cnt);
    assign op_row = m4ci_pkg::skip_idx(cur_op.rsel, r_ci[1:0]);
    assign op_col = m4ci_pkg::skip_idx(cur_op.csel, r_ci[3:2]);

    assign o_in_ready = (r_state == m4ci_pkg::S_LOAD);
    assign mat_we     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        mat_raddr = {op_col, op_row};
        cof_raddr = {r_cnt[1:0], 2'b00};
        if (r_state == m4ci_pkg::S_DET_RD) begin
            mat_raddr = {r_cnt[1:0], 2'b00};
        end
        if (r_state == m4ci_pkg::S_DIV_RD) begin
            cof_raddr = {r_cnt[1:0], r_cnt[3:2]};
        end
    end

    m4ci_ram #(
        .WIDTH(m4ci_pkg::ELEM_W),
        .DEPTH(16)
    ) u_mat_ram (
        .i_clk  (i_clk),
        .i_we   (mat_we),
        .i_waddr(r_cnt),
        .i_wdata(i_elem_value),
        .i_raddr(mat_raddr),
        .o_rdata(mat_rdata)
    );

    assign cof_we    = (r_state == m4ci_pkg::S_COF_WR);
    assign cof_wdata = (r_ci[0] ^ r_ci[2]) ? -r_acc3 : r_acc3;

    m4ci_ram #(
        .WIDTH(m4ci_pkg::COF_W),
        .DEPTH(16)
    ) u_cof_ram (
        .i_clk  (i_clk),
        .i_we   (cof_we),
        .i_waddr(r_ci),
        .i_wdata(cof_wdata),
        .i_raddr(cof_raddr),
        .o_rdata(cof_rdata)
    );

    always_comb begin
        mul_y = $signed(mat_rdata);
        if (r_state == m4ci_pkg::S_DET_EX) begin
            mul_x = $signed(cof_rdata);
        end else if (cur_op.kind == m4ci_pkg::K_M2SET || cur_op.kind == m4ci_pkg::K_M2SUB) begin
            mul_x = m4ci_pkg::COF_W'(r_opa);
        end else begin
            mul_x = m4ci_pkg::COF_W'(r_acc2);
        end
        mul_p = mul_x * mul_y;
    end

    assign cv   = $signed(cof_rdata);
    assign cmag = cv[m4ci_pkg::COF_W-1] ? m4ci_pkg::COF_W'(-cv) : cof_rdata;
    assign ge   = (r_rem >= r_dsh);

    always_comb begin
        q_sat = r_q[m4ci_pkg::QSH] ||
                (r_q[m4ci_pkg::QSH-1:0] > (r_neg ? 17'd32768 : 17'd32767));
        if (q_sat) begin
            q_val = r_neg ? 16'h8000 : 16'h7FFF;
        end else begin
            q_val = r_neg ? (16'd0 - r_q[15:0]) : r_q[15:0];
        end
        id_val = (r_cnt[1:0] == r_cnt[3:2]) ? 16'(1 << FRAC_BITS) : 16'd0;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ci    = r_ci;
        n_bit   = r_bit;
        unique case (r_state)
            m4ci_pkg::S_LOAD: begin
                if (mat_we) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        n_state = m4ci_pkg::S_COF_RD;
                        n_ci    = 4'd0;
                    end
                end
            end
            m4ci_pkg::S_COF_RD: n_state = m4ci_pkg::S_COF_EX;
            m4ci_pkg::S_COF_EX: n_state = m4ci_pkg::S_COF_AC;
            m4ci_pkg::S_COF_AC: begin
                if (r_cnt == m4ci_pkg::LAST_OP) begin
                    n_state = m4ci_pkg::S_COF_WR;
                    n_cnt   = 4'd0;
                end else begin
                    n_state = m4ci_pkg::S_COF_RD;
                    n_cnt   = r_cnt + 4'd1;
                end
            end
            m4ci_pkg::S_COF_WR: begin
                n_ci = r_ci + 4'd1;
                n_state = (r_ci == 4'd15) ? m4ci_pkg::S_DET_RD : m4ci_pkg::S_COF_RD;
            end
            m4ci_pkg::S_DET_RD: n_state = m4ci_pkg::S_DET_EX;
            m4ci_pkg::S_DET_EX: n_state = m4ci_pkg::S_DET_AC;
            m4ci_pkg::S_DET_AC: begin
                if (r_cnt == 4'd3) begin
                    n_state = m4ci_pkg::S_DET_FIN;
                    n_cnt   = 4'd0;
                end else begin
                    n_state = m4ci_pkg::S_DET_RD;
                    n_cnt   = r_cnt + 4'd1;
                end
            end
            m4ci_pkg::S_DET_FIN: begin
                n_state = (r_det == '0) ? m4ci_pkg::S_DIV_OUT : m4ci_pkg::S_DIV_RD;
            end
            m4ci_pkg::S_DIV_RD: n_state = m4ci_pkg::S_DIV_INIT;
            m4ci_pkg::S_DIV_INIT: begin
                n_state = m4ci_pkg::S_DIV_STEP;
                n_bit   = 5'(m4ci_pkg::QSH);
            end
            m4ci_pkg::S_DIV_STEP: begin
                n_bit = r_bit - 5'd1;
                if (r_bit == 5'd0) begin
                    n_state = m4ci_pkg::S_DIV_OUT;
                end
            end
            m4ci_pkg::S_DIV_OUT: begin
                if (out_free) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        n_state = m4ci_pkg::S_LOAD;
                    end else if (!r_sing) begin
                        n_state = m4ci_pkg::S_DIV_RD;
                    end
                end
            end
            default: n_state = m4ci_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= m4ci_pkg::S_LOAD;
            r_cnt       <= 4'd0;
            r_ci        <= 4'd0;
            r_bit       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ci    <= n_ci;
            r_bit   <= n_bit;
            if (r_state == m4ci_pkg::S_DIV_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == m4ci_pkg::S_COF_EX) begin
            if (cur_op.kind == m4ci_pkg::K_LD) begin
                r_opa <= $signed(mat_rdata);
            end
            r_prod <= mul_p;
        end
        if (r_state == m4ci_pkg::S_DET_EX) begin
            r_prod <= mul_p;
        end
        if (r_state == m4ci_pkg::S_COF_AC) begin
            case (cur_op.kind)
                m4ci_pkg::K_M2SET: r_acc2 <= r_prod[m4ci_pkg::MIN2_W-1:0];
                m4ci_pkg::K_M2SUB: r_acc2 <= r_acc2 - r_prod[m4ci_pkg::MIN2_W-1:0];
                m4ci_pkg::K_M3SET: r_acc3 <= r_prod[m4ci_pkg::COF_W-1:0];
                m4ci_pkg::K_M3SUB: r_acc3 <= r_acc3 - r_prod[m4ci_pkg::COF_W-1:0];
                m4ci_pkg::K_M3ADD: r_acc3 <= r_acc3 + r_prod[m4ci_pkg::COF_W-1:0];
                default: ;
            endcase
        end
        if (r_state == m4ci_pkg::S_COF_WR && r_ci == 4'd15) begin
            r_det <= '0;
        end
        if (r_state == m4ci_pkg::S_DET_AC) begin
            r_det <= r_det + m4ci_pkg::DET_W'(r_prod);
        end
        if (r_state == m4ci_pkg::S_DET_FIN) begin
            r_sing <= (r_det == '0);
            r_dneg <= r_det[m4ci_pkg::DET_W-1];
            r_dmag <= r_det[m4ci_pkg::DET_W-1] ? m4ci_pkg::DET_W'(-r_det) : r_det;
        end
        if (r_state == m4ci_pkg::S_DIV_INIT) begin
            r_neg <= cv[m4ci_pkg::COF_W-1] ^ r_dneg;
            r_rem <= m4ci_pkg::DSH_W'(cmag) << ESH;
            r_dsh <= m4ci_pkg::DSH_W'(r_dmag) << m4ci_pkg::QSH;
            r_q   <= '0;
        end
        if (r_state == m4ci_pkg::S_DIV_STEP) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[m4ci_pkg::QSH-1:0], ge};
            r_dsh <= r_dsh >> 1;
        end
        if (r_state == m4ci_pkg::S_DIV_OUT && out_free) begin
            r_inv_value <= r_sing ? id_val : q_val;
            r_inv_index <= r_cnt;
            r_inv_last  <= (r_cnt == 4'd15);
            r_singular  <= r_sing;
            r_saturated <= !r_sing && q_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_inv_value = r_inv_value;
    assign o_inv_index = r_inv_index;
    assign o_inv_last  = r_inv_last;
    assign o_singular  = r_singular;
    assign o_saturated = r_saturated;

endmodule

### rtl/m4ci_checker.sv
// Port-level checker for the 4x4 inverse core, bound to the top level.
module m4ci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_inv_value,
    input logic [3:0]  o_inv_index,
    input logic        o_inv_last,
    input logic        o_singular,
    input logic        o_saturated
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_inv_value)
                                       && $stable(o_inv_index))
        else $error("result word dropped or changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_inv_last == (o_inv_index == 4'd15)))
        else $error("last flag does not match index");

    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> !o_saturated)
        else $error("singular word marked saturated");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear output and ready");

endmodule

bind mat4_cofactor_inverse_core m4ci_checker u_m4ci_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_inv_value(o_inv_value),
    .o_inv_index(o_inv_index),
    .o_inv_last (o_inv_last),
    .o_singular (o_singular),
    .o_saturated(o_saturated)
);

### tb/testbench.sv
// Self-checking testbench for the 4x4 cofactor matrix inverse core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  index;
        logic        last;
        logic        singular;
        logic        saturated;
    } inv_word_t;

    class inverse_scoreboard;
        logic [15:0] elems[16];
        int unsigned fill;
        inv_word_t   pending[$];
        int unsigned errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function longint elem(int r, int c);
            return longint'($signed(elems[r + 4 * c]));
        endfunction

        function longint cofactor(int i, int j);
            int rr[3];
            int cc[3];
            int n;
            int m;
            longint d3;
            n = 0;
            m = 0;
            for (int t = 0; t < 4; t++) begin
                if (t != i) begin
                    rr[n] = t;
                    n++;
                end
                if (t != j) begin
                    cc[m] = t;
                    m++;
                end
            end
            d3 = elem(rr[0], cc[0]) * (elem(rr[1], cc[1]) * elem(rr[2], cc[2])
                                      - elem(rr[1], cc[2]) * elem(rr[2], cc[1]))
               - elem(rr[0], cc[1]) * (elem(rr[1], cc[0]) * elem(rr[2], cc[2])
                                      - elem(rr[1], cc[2]) * elem(rr[2], cc[0]))
               + elem(rr[0], cc[2]) * (elem(rr[1], cc[0]) * elem(rr[2], cc[1])
                                      - elem(rr[1], cc[1]) * elem(rr[2], cc[0]));
            return ((i + j) % 2) ? -d3 : d3;
        endfunction

        function void note_elem(logic [15:0] v);
            longint cof[16];
            logic signed [127:0] det;
            logic signed [127:0] num;
            logic signed [127:0] q;
            inv_word_t w;
            elems[fill] = v;
            if (fill < 15) begin
                fill++;
                return;
            end
            fill = 0;
            for (int k = 0; k < 16; k++) cof[k] = cofactor(k % 4, k / 4);
            det = 0;
            for (int c = 0; c < 4; c++) det += 128'(elem(0, c)) * 128'(cof[4 * c]);
            for (int k = 0; k < 16; k++) begin
                w.index = k[3:0];
                w.last = (k == 15);
                w.singular = (det == 0);
                w.saturated = 0;
                if (det == 0) begin
                    w.value = ((k % 4) == (k / 4)) ? 16'h1000 : 16'h0000;
                end else begin
                    num = 128'(cof[(k / 4) + 4 * (k % 4)]) <<< 24;
                    q = num / det;
                    if (q > 32767) begin
                        w.value = 16'h7fff;
                        w.saturated = 1;
                    end else if (q < -32768) begin
                        w.value = 16'h8000;
                        w.saturated = 1;
                    end else begin
                        w.value = q[15:0];
                    end
                end
                pending.push_back(w);
            end
        endfunction

        function void check_word(inv_word_t got);
            inv_word_t exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word value=%h index=%0d", $time, got.value, got.index);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w) begin
                $display("%0t: mismatch exp v=%h i=%0d l=%b s=%b sat=%b got v=%h i=%0d l=%b s=%b sat=%b",
                         $time, exp_w.value, exp_w.index, exp_w.last, exp_w.singular,
                         exp_w.saturated, got.value, got.index, got.last, got.singular,
                         got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_elem_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_inv_value;
    logic [3:0]  o_inv_index;
    logic        o_inv_last;
    logic        o_singular;
    logic        o_saturated;

    mat4_cofactor_inverse_core dut (.*);

    inverse_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int quiet_cycles;

    initial i_clk = 0;
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        inv_word_t w;
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_elem(i_elem_value);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            w.value = o_inv_value;
            w.index = o_inv_index;
            w.last = o_inv_last;
            w.singular = o_singular;
            w.saturated = o_saturated;
            sb.check_word(w);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) i_out_ready <= 0;
        else i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_elem_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_elem(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8192)) - 4096);
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic send_matrix(int mode);
        for (int k = 0; k < 16; k++) begin
            if (mode == 4) send_word(((k % 5) == 0) ? 16'h1000 : 16'h0000);
            else if (mode == 5) send_word((k % 4 == 1) ? 16'h0000 : rand_elem(1));
            else if (mode == 6) send_word(((k % 5) == 0) ? 16'(16 + $urandom_range(200)) : 16'h0);
            else send_word(rand_elem(mode));
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_elem_value = 0;
        i_out_ready = 0;
        hold_off = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        send_matrix(4);
        send_matrix(5);
        send_matrix(6);
        send_matrix(3);
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                send_matrix(1);
                send_matrix(2);
            end
        join
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 61 : 18) : 0;
            recv_stall_pct = (p == 2) ? 61 : ((p == 3) ? 18 : 0);
            for (int m = 0; m < 3; m++) send_matrix($urandom_range(6));
        end
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
